/* rtl/ird_pkg.sv */
// ----------------------------------------------------------------------------
// ird_pkg
// Widths, reset values, register indexes, phase codes and shared types of the
// pulse-distance infrared decoder.
// ----------------------------------------------------------------------------
package ird_pkg;

    localparam int CODE_BITS  = 32;
    localparam int PHASE_W    = $clog2(CODE_BITS + 2);
    localparam int TICK_W     = 32;
    localparam int GAP_W      = 16;
    localparam int CODE_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAP_W-1:0]  RST_START_GAP  = GAP_W'(500);
    localparam logic [GAP_W-1:0]  RST_LEADER_MIN = GAP_W'(224);
    localparam logic [GAP_W-1:0]  RST_LEADER_MAX = GAP_W'(298);
    localparam logic [GAP_W-1:0]  RST_ONE_MIN    = GAP_W'(32);
    localparam logic [CODE_W-1:0] RST_POWER_OFF  = CODE_W'(32'h00F7_40BF);

    localparam logic [PHASE_W-1:0] PH_IDLE      = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PH_LEADER    = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PH_FIRST_BIT = PHASE_W'(2);
    localparam logic [PHASE_W-1:0] PH_LAST_BIT  = PHASE_W'(CODE_BITS + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_GAP  = 3'd0,
        REG_LEADER_MIN = 3'd1,
        REG_LEADER_MAX = 3'd2,
        REG_ONE_MIN    = 3'd3,
        REG_POWER_OFF  = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [GAP_W-1:0]  start_gap_ticks;
        logic [GAP_W-1:0]  leader_min_ticks;
        logic [GAP_W-1:0]  leader_max_ticks;
        logic [GAP_W-1:0]  one_min_ticks;
        logic [CODE_W-1:0] power_off_code;
    } t_cfg;

    typedef struct packed {
        logic              frame_done;
        logic [CODE_W-1:0] key_code;
        logic              led_toggle;
    } t_result;

endpackage

/* rtl/ird_if.sv */
// ----------------------------------------------------------------------------
// ird_if
// Valid/ready channels of the decoder: edge requests in, results out, and
// register writes.
// ----------------------------------------------------------------------------
interface ird_edge_if;
    logic                        valid;
    logic                        ready;
    logic [ird_pkg::TICK_W-1:0]  edge_tick;

    modport source (output valid, output edge_tick, input ready);
    modport sink   (input valid, input edge_tick, output ready);
endinterface

interface ird_result_if;
    logic                        valid;
    logic                        ready;
    logic                        frame_done;
    logic [ird_pkg::CODE_W-1:0]  key_code;
    logic                        led_toggle;

    modport source (output valid, output frame_done, output key_code, output led_toggle,
                    input ready);
    modport sink   (input valid, input frame_done, input key_code, input led_toggle,
                    output ready);
endinterface

interface ird_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ird_pkg::CFG_IDX_W-1:0]   index;
    logic [ird_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/ir_pulse_distance_decoder.sv */
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder
// Pulse-distance infrared remote decoder: measures gaps between receiver
// falling edges and assembles 32-bit codes.
// ----------------------------------------------------------------------------
// Each request on i_edge carries the timer tick of one receiver falling edge
// and yields exactly one result on o_result, in order. A request passes
// through an edge register and then a result register, which holds while
// o_result stalls; one request is taken every cycle while o_result keeps
// draining, the rate being set by the combinational gap compare and shift
// update. key_code and led_toggle are zero unless frame_done is set.
// Write the thresholds and power-off code through i_cfg only while no
// request is in flight; the register port is always ready.
module ir_pulse_distance_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ird_edge_if.sink     i_edge,
    ird_cfg_if.sink      i_cfg,
    ird_result_if.source o_result
);

    ird_pkg::t_cfg w_cfg;

    ird_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    ird_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_edge   (i_edge),
        .o_result (o_result)
    );

endmodule

/* rtl/ird_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ird_cfg_regs
// Configuration register file: timing thresholds and the power-off code.
// ----------------------------------------------------------------------------
module ird_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ird_cfg_if.sink       i_cfg,
    output ird_pkg::t_cfg o_cfg
);

    ird_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_gap_ticks  <= ird_pkg::RST_START_GAP;
            r_cfg.leader_min_ticks <= ird_pkg::RST_LEADER_MIN;
            r_cfg.leader_max_ticks <= ird_pkg::RST_LEADER_MAX;
            r_cfg.one_min_ticks    <= ird_pkg::RST_ONE_MIN;
            r_cfg.power_off_code   <= ird_pkg::RST_POWER_OFF;
        end else if (i_cfg.valid) begin
            case (ird_pkg::t_cfg_reg'(i_cfg.index))
                ird_pkg::REG_START_GAP: begin
                    r_cfg.start_gap_ticks <= i_cfg.data[ird_pkg::GAP_W-1:0];
                end
                ird_pkg::REG_LEADER_MIN: begin
                    r_cfg.leader_min_ticks <= i_cfg.data[ird_pkg::GAP_W-1:0];
                end
                ird_pkg::REG_LEADER_MAX: begin
                    r_cfg.leader_max_ticks <= i_cfg.data[ird_pkg::GAP_W-1:0];
                end
                ird_pkg::REG_ONE_MIN: begin
                    r_cfg.one_min_ticks <= i_cfg.data[ird_pkg::GAP_W-1:0];
                end
                ird_pkg::REG_POWER_OFF: begin
                    r_cfg.power_off_code <= i_cfg.data[ird_pkg::CODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/ird_core.sv */
// ----------------------------------------------------------------------------
// ird_core
// Decode pipeline: edge register, gap measure and frame tracking, result
// register.
// ----------------------------------------------------------------------------
module ird_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ird_pkg::t_cfg i_cfg,
    ird_edge_if.sink      i_edge,
    ird_result_if.source  o_result
);

    logic                           r_in_valid;
    logic [ird_pkg::TICK_W-1:0]     r_in_tick;
    logic [ird_pkg::TICK_W-1:0]     r_last_tick;
    logic [ird_pkg::PHASE_W-1:0]    r_phase;
    logic [ird_pkg::CODE_W-1:0]     r_shift;
    logic                           r_out_valid;
    ird_pkg::t_result               r_out;

    logic                           w_out_free;
    logic                           w_step;
    logic [ird_pkg::TICK_W-1:0]     w_gap;
    logic                           w_bit;
    logic [ird_pkg::PHASE_W-1:0]    n_phase;
    logic [ird_pkg::CODE_W-1:0]     n_shift;
    ird_pkg::t_result               n_out;

    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_step       = r_in_valid && w_out_free;
    assign i_edge.ready = !r_in_valid || w_out_free;

    assign w_gap = r_in_tick - r_last_tick;
    assign w_bit = (w_gap >= ird_pkg::TICK_W'(i_cfg.one_min_ticks));

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_out   = '0;
        if (w_gap >= ird_pkg::TICK_W'(i_cfg.start_gap_ticks)) begin
            n_phase = ird_pkg::PH_LEADER;
            n_shift = '0;
        end else if (r_phase == ird_pkg::PH_LEADER) begin
            if ((w_gap >= ird_pkg::TICK_W'(i_cfg.leader_min_ticks)) &&
                (w_gap <= ird_pkg::TICK_W'(i_cfg.leader_max_ticks))) begin
                n_phase = ird_pkg::PH_FIRST_BIT;
            end
        end else if (r_phase >= ird_pkg::PH_FIRST_BIT) begin
            n_shift = {r_shift[ird_pkg::CODE_W-2:0], w_bit};
            if (r_phase >= ird_pkg::PH_LAST_BIT) begin
                n_out.frame_done = 1'b1;
                n_out.key_code   = n_shift;
                n_out.led_toggle = (n_shift == i_cfg.power_off_code);
                n_phase          = ird_pkg::PH_IDLE;
            end else begin
                n_phase = r_phase + ird_pkg::PHASE_W'(1);
            end
        end
    end

    // edge register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_edge.ready) begin
            r_in_valid <= i_edge.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_edge.ready && i_edge.valid) begin
            r_in_tick <= i_edge.edge_tick;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tick <= '0;
            r_phase     <= ird_pkg::PH_IDLE;
            r_shift     <= '0;
        end else if (w_step) begin
            r_last_tick <= r_in_tick;
            r_phase     <= n_phase;
            r_shift     <= n_shift;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.frame_done = r_out.frame_done;
    assign o_result.key_code   = r_out.key_code;
    assign o_result.led_toggle = r_out.led_toggle;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= ird_pkg::PH_LAST_BIT)
        else $error("phase beyond last data bit");

    a_led_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.led_toggle) |-> r_out.frame_done)
        else $error("led toggle without completed frame");

    a_code_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.frame_done) |-> (r_out.key_code == '0))
        else $error("key code set without completed frame");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && n_out.frame_done) |=> (r_phase == ird_pkg::PH_IDLE))
        else $error("frame not closed after last bit");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> ($stable(r_phase) && $stable(r_shift) && $stable(r_last_tick)))
        else $error("frame state moved without a request");

endmodule

/* bench/ir_pulse_distance_decoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder_test
// Drives falling-edge tick requests into the decoder and checks every result
// against a cycle-free decoder model kept in step with each accepted request.
// Threshold and power-off settings change between bursts. Bursts mix
// well-formed frames with random codes, broken frames and noise, and both
// sides idle at random. One long result hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder_test;

    localparam int CLK_HALF        = 5;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    localparam logic [ird_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [ird_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [ird_pkg::TICK_W-1:0] tick;
        logic [4:0]                 delay;
    } t_tick_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ird_edge_if   tick_bus();
    ird_cfg_if    reg_bus();
    ird_result_if result_bus();

    ir_pulse_distance_decoder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_edge   (tick_bus),
        .i_cfg    (reg_bus),
        .o_result (result_bus)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // decoder model state
    ird_pkg::t_cfg                reg_model;
    logic [ird_pkg::TICK_W-1:0]   last_tick;
    logic [ird_pkg::PHASE_W-1:0]  rx_phase;
    logic [ird_pkg::CODE_W-1:0]   rx_shift;
    ird_pkg::t_result             pending_decodes[$];

    t_tick_req                    tick_queue[$];
    t_tick_req                    next_req;
    logic [ird_pkg::TICK_W-1:0]   stim_tick;
    int                           pushed_total;
    int                           accepted_total;
    int                           send_count;
    int                           recv_wait;
    int                           recv_next;
    int                           recv_mode;
    logic                         recv_hold_off;
    logic                         hold_off_start;
    int                           decode_errors;
    int                           stall_cycles;
    ird_pkg::t_result             got;
    ird_pkg::t_result             want;

    function automatic void decode_edge(input logic [ird_pkg::TICK_W-1:0] tick);
        logic [ird_pkg::TICK_W-1:0] gap;
        ird_pkg::t_result           res;
        gap       = tick - last_tick;
        last_tick = tick;
        res       = '0;
        if (gap >= ird_pkg::TICK_W'(reg_model.start_gap_ticks)) begin
            rx_phase = ird_pkg::PH_LEADER;
            rx_shift = '0;
        end else if (rx_phase == ird_pkg::PH_LEADER) begin
            if (gap >= ird_pkg::TICK_W'(reg_model.leader_min_ticks) &&
                gap <= ird_pkg::TICK_W'(reg_model.leader_max_ticks))
                rx_phase = ird_pkg::PH_FIRST_BIT;
        end else if (rx_phase >= ird_pkg::PH_FIRST_BIT) begin
            rx_shift = {rx_shift[ird_pkg::CODE_W-2:0],
                        gap >= ird_pkg::TICK_W'(reg_model.one_min_ticks)};
            if (rx_phase >= ird_pkg::PH_LAST_BIT) begin
                res.frame_done = 1'b1;
                res.key_code   = rx_shift;
                res.led_toggle = (rx_shift == reg_model.power_off_code);
                rx_phase       = ird_pkg::PH_IDLE;
            end else begin
                rx_phase = rx_phase + ird_pkg::PHASE_W'(1);
            end
        end
        pending_decodes.push_back(res);
    endfunction

    function automatic int draw_wait(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(17, 0);
            default: return ($urandom_range(3, 0) == 0) ? $urandom_range(17, 0) : 0;
        endcase
    endfunction

    function automatic logic [31:0] span(input logic [31:0] lo, input logic [31:0] hi);
        if (hi <= lo) return lo;
        return lo + $urandom_range(hi - lo, 0);
    endfunction

    function automatic logic [31:0] pick_start_gap();
        logic [31:0] start;
        start = 32'(reg_model.start_gap_ticks);
        case ($urandom_range(3, 0))
            0: return start;
            1: return start + $urandom_range(255, 0);
            2: return start + $urandom_range(65535, 0);
            default: return $urandom | 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_leader_gap();
        logic [31:0] start, lo, hi;
        start = 32'(reg_model.start_gap_ticks);
        lo    = 32'(reg_model.leader_min_ticks);
        hi    = 32'(reg_model.leader_max_ticks);
        if (start == 0) return 0;
        if (hi > start - 1) hi = start - 1;
        if (lo > hi) return span(0, start - 1);
        case ($urandom_range(3, 0))
            0: return lo;
            1: return hi;
            default: return span(lo, hi);
        endcase
    endfunction

    function automatic logic [31:0] pick_bad_leader();
        logic [31:0] start, lo, hi;
        start = 32'(reg_model.start_gap_ticks);
        lo    = 32'(reg_model.leader_min_ticks);
        hi    = 32'(reg_model.leader_max_ticks);
        if (start == 0) return 0;
        if (lo > 0 && ($urandom_range(1, 0) == 0 || hi + 1 >= start))
            return span(0, (lo - 1 < start - 1) ? lo - 1 : start - 1);
        if (hi + 1 < start) return span(hi + 1, start - 1);
        return 0;
    endfunction

    function automatic logic [31:0] pick_bit_gap(input logic one);
        logic [31:0] start, thr, hi;
        start = 32'(reg_model.start_gap_ticks);
        thr   = 32'(reg_model.one_min_ticks);
        if (start == 0) return 0;
        if (one) begin
            if (thr > start - 1) return span(0, start - 1);
            return ($urandom_range(3, 0) == 0) ? thr : span(thr, start - 1);
        end
        if (thr == 0) return span(0, start - 1);
        hi = (thr - 1 < start - 1) ? thr - 1 : start - 1;
        return ($urandom_range(3, 0) == 0) ? hi : span(0, hi);
    endfunction

    function automatic logic [ird_pkg::CODE_W-1:0] pick_code();
        int pick;
        pick = $urandom_range(19, 0);
        if (pick < 6) return reg_model.power_off_code;
        if (pick == 6) return '0;
        if (pick == 7) return '1;
        return $urandom;
    endfunction

    task automatic push_gap(input logic [31:0] gap, input int mode);
        stim_tick = stim_tick + gap;
        tick_queue.push_back({stim_tick, 5'(draw_wait(mode))});
        pushed_total++;
    endtask

    task automatic push_tick(input logic [31:0] tick, input int mode);
        push_gap(tick - stim_tick, mode);
    endtask

    task automatic push_frame(input logic [ird_pkg::CODE_W-1:0] code, input int n_bits,
                              input int n_bad, input int mode);
        logic [31:0] gap;
        gap = pick_start_gap();
        // land the frame just below the counter rollover now and then
        if ($urandom_range(9, 0) == 0 &&
            (32'hFFFF_FFC0 - stim_tick) >= 32'(reg_model.start_gap_ticks))
            gap = 32'hFFFF_FFC0 - stim_tick;
        push_gap(gap, mode);
        repeat (n_bad) push_gap(pick_bad_leader(), mode);
        push_gap(pick_leader_gap(), mode);
        for (int b = ird_pkg::CODE_BITS - 1; b >= ird_pkg::CODE_BITS - n_bits; b--)
            push_gap(pick_bit_gap(code[b]), mode);
    endtask

    task automatic push_noise(input int n_items, input int mode);
        repeat (n_items) begin
            if ($urandom_range(1, 0) == 0) push_gap($urandom, mode);
            else push_gap($urandom_range(32'h1FF, 0), mode);
        end
    endtask

    task automatic push_random(input int n_items);
        int stop_at;
        int pick;
        int mode;
        stop_at = pushed_total + n_items;
        while (pushed_total < stop_at) begin
            mode = $urandom_range(2, 0);
            pick = $urandom_range(99, 0);
            if (pick < 65)
                push_frame(pick_code(), ird_pkg::CODE_BITS,
                           ($urandom_range(4, 0) == 0), mode);
            else if (pick < 80)
                push_frame(pick_code(), $urandom_range(ird_pkg::CODE_BITS - 1, 0),
                           $urandom_range(3, 0), mode);
            else
                push_noise($urandom_range(5, 1), mode);
        end
    endtask

    task automatic write_reg(input logic [ird_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ird_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= value;
        @(posedge i_clk);
        while (!reg_bus.ready) @(posedge i_clk);
        reg_bus.valid <= 1'b0;
        case (idx)
            ird_pkg::REG_START_GAP:
                reg_model.start_gap_ticks  = value[ird_pkg::GAP_W-1:0];
            ird_pkg::REG_LEADER_MIN:
                reg_model.leader_min_ticks = value[ird_pkg::GAP_W-1:0];
            ird_pkg::REG_LEADER_MAX:
                reg_model.leader_max_ticks = value[ird_pkg::GAP_W-1:0];
            ird_pkg::REG_ONE_MIN:
                reg_model.one_min_ticks    = value[ird_pkg::GAP_W-1:0];
            ird_pkg::REG_POWER_OFF:
                reg_model.power_off_code   = value[ird_pkg::CODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (accepted_total != pushed_total || pending_decodes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        recv_mode = $urandom_range(2, 0);
    endtask

    task automatic write_all(input logic [15:0] start, input logic [15:0] lmin,
                             input logic [15:0] lmax, input logic [15:0] one,
                             input logic [31:0] power);
        write_reg(ird_pkg::REG_START_GAP,  {16'($urandom_range(16'hFFFF, 0)), start});
        write_reg(ird_pkg::REG_LEADER_MIN, {16'($urandom_range(16'hFFFF, 0)), lmin});
        write_reg(ird_pkg::REG_LEADER_MAX, {16'($urandom_range(16'hFFFF, 0)), lmax});
        write_reg(ird_pkg::REG_ONE_MIN,    {16'($urandom_range(16'hFFFF, 0)), one});
        write_reg(ird_pkg::REG_POWER_OFF,  power);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_bus.valid <= 1'b0;
            send_count     <= 0;
        end else begin
            if (tick_bus.valid && tick_bus.ready) begin
                decode_edge(tick_bus.edge_tick);
                accepted_total++;
            end
            if (tick_bus.valid && !tick_bus.ready) begin
                // hold until taken
            end else if (tick_queue.size() > 0 && send_count >= tick_queue[0].delay) begin
                next_req = tick_queue.pop_front();
                tick_bus.valid     <= 1'b1;
                tick_bus.edge_tick <= next_req.tick;
                send_count         <= 0;
            end else begin
                tick_bus.valid <= 1'b0;
                if (tick_queue.size() > 0) send_count <= send_count + 1;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            recv_wait        <= 0;
        end else begin
            recv_next = recv_wait;
            if (result_bus.valid && result_bus.ready) begin
                got = {result_bus.frame_done, result_bus.key_code, result_bus.led_toggle};
                if (pending_decodes.size() == 0) begin
                    decode_errors++;
                    if (decode_errors <= MAX_REPORTS)
                        $display("unexpected result: done=%0b code=%08h led=%0b",
                                 got.frame_done, got.key_code, got.led_toggle);
                end else begin
                    want = pending_decodes.pop_front();
                    if (got.frame_done !== want.frame_done || got.key_code !== want.key_code
                        || got.led_toggle !== want.led_toggle) begin
                        decode_errors++;
                        if (decode_errors <= MAX_REPORTS)
                            $display({"result mismatch: expected done=%0b code=%08h ",
                                      "led=%0b, got done=%0b code=%08h led=%0b"},
                                     want.frame_done, want.key_code, want.led_toggle,
                                     got.frame_done, got.key_code, got.led_toggle);
                    end
                end
                if ($urandom_range(63, 0) == 0) recv_mode = $urandom_range(2, 0);
                recv_next = draw_wait(recv_mode);
            end
            if (recv_hold_off) begin
                result_bus.ready <= 1'b0;
                recv_wait        <= recv_next;
            end else if (recv_next > 0) begin
                result_bus.ready <= 1'b0;
                recv_wait        <= recv_next - 1;
            end else begin
                result_bus.ready <= 1'b1;
                recv_wait        <= 0;
            end
        end
    end

    // long result hold-off while requests keep coming
    initial begin
        recv_hold_off = 1'b0;
        wait (hold_off_start);
        @(posedge i_clk);
        recv_hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        recv_hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((tick_bus.valid && tick_bus.ready) || (result_bus.valid && result_bus.ready)
            || (reg_bus.valid && reg_bus.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[ir_pulse_distance_decoder] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        tick_bus.valid     = 1'b0;
        tick_bus.edge_tick = '0;
        reg_bus.valid      = 1'b0;
        reg_bus.index      = '0;
        reg_bus.data       = '0;
        result_bus.ready   = 1'b0;
        reg_model = {ird_pkg::RST_START_GAP, ird_pkg::RST_LEADER_MIN,
                     ird_pkg::RST_LEADER_MAX, ird_pkg::RST_ONE_MIN,
                     ird_pkg::RST_POWER_OFF};
        last_tick      = '0;
        rx_phase       = ird_pkg::PH_IDLE;
        rx_shift       = '0;
        stim_tick      = '0;
        pushed_total   = 0;
        accepted_total = 0;
        recv_mode      = 1;
        hold_off_start = 1'b0;
        decode_errors  = 0;
        stall_cycles   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset thresholds: window edges, bit threshold, restarts, tick rollover
        push_tick(5, 1);
        push_gap(500, 1);
        push_gap(223, 1);
        push_gap(299, 1);
        push_gap(224, 1);
        push_gap(31, 1);
        push_gap(32, 1);
        push_gap(0, 1);
        push_gap(499, 1);
        push_gap(500, 1);
        push_gap(298, 1);
        push_gap(40, 1);
        push_tick(32'hFFFF_FFF0, 1);
        push_tick(32'h0000_0100, 1);
        push_gap(1, 1);
        push_tick(32'hFFFF_FFFF, 1);
        push_tick(32'h0000_0000, 1);
        wait_idle();

        push_frame(reg_model.power_off_code, ird_pkg::CODE_BITS, 0, 0);
        push_frame(pick_code(), ird_pkg::CODE_BITS, 0, 0);
        hold_off_start = 1'b1;
        push_random(150);
        wait_idle();

        // every gap restarts; unmapped indexes change nothing
        write_reg(ird_pkg::REG_START_GAP, 32'hFFFF_0000);
        write_reg(REG_UNMAPPED_LO, 32'h0000_0001);
        write_reg(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
        push_random(30);
        wait_idle();

        // every bit reads one; all-ones code toggles
        write_all(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        push_random(80);
        wait_idle();

        // every bit reads zero; zero code toggles
        write_all(16'hFFFF, 16'h0010, 16'h0020, 16'hFFFF, 32'h0000_0000);
        push_random(80);
        wait_idle();

        // empty leader window
        write_all(16'd500, 16'h0100, 16'h00FF, 16'd32, $urandom);
        push_random(40);
        wait_idle();

        repeat (4) begin
            logic [15:0] start, lmin, lmax, one;
            start = 16'($urandom_range(16'hFFFF, 16));
            lmin  = 16'($urandom_range(start - 1, 0));
            lmax  = 16'($urandom_range(start - 1, lmin));
            one   = 16'($urandom_range(start, 0));
            write_all(start, lmin, lmax, one, $urandom);
            push_random(80);
            wait_idle();
        end

        repeat (4) @(posedge i_clk);
        if (decode_errors == 0 && pending_decodes.size() == 0)
            $display("[ir_pulse_distance_decoder] OK");
        else
            $display("[ir_pulse_distance_decoder] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ird_pkg.sv
rtl/ird_if.sv
rtl/ird_cfg_regs.sv
rtl/ird_core.sv
rtl/ir_pulse_distance_decoder.sv
bench/ir_pulse_distance_decoder_test.sv
